/* rtl/phc_pkg.sv */
// Shared types, hazard class codes and opcode helpers for the hazard classifier.
package phc_pkg;

  // Opcode codes
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_LOAD  = 4'd5;
  localparam logic [3:0] OP_STORE = 4'd6;
  localparam logic [3:0] OP_BR    = 4'd7;
  localparam logic [3:0] OP_BRNEQ = 4'd9;
  localparam logic [3:0] OP_HALT  = 4'd10;

  // Hazard class codes
  localparam logic [4:0] CLS_NONE              = 5'd0;
  localparam logic [4:0] CLS_EXE_SRC1_MEM_SRC2 = 5'd1;
  localparam logic [4:0] CLS_EXE_SRC1_WB_SRC2  = 5'd2;
  localparam logic [4:0] CLS_EXE_SRC1          = 5'd3;
  localparam logic [4:0] CLS_MEM_SRC1_EXE_SRC2 = 5'd4;
  localparam logic [4:0] CLS_MEM_SRC1_WB_SRC2  = 5'd5;
  localparam logic [4:0] CLS_MEM_SRC1          = 5'd6;
  localparam logic [4:0] CLS_WB_SRC1_EXE_SRC2  = 5'd7;
  localparam logic [4:0] CLS_WB_SRC1_MEM_SRC2  = 5'd8;
  localparam logic [4:0] CLS_WB_SRC1           = 5'd9;
  localparam logic [4:0] CLS_EXE_SRC2          = 5'd10;
  localparam logic [4:0] CLS_MEM_SRC2          = 5'd11;
  localparam logic [4:0] CLS_WB_SRC2           = 5'd12;
  localparam logic [4:0] CLS_EXE_DST_MEM_SRC1  = 5'd13;
  localparam logic [4:0] CLS_EXE_DST_MEM_SRC2  = 5'd14;
  localparam logic [4:0] CLS_EXE_DST           = 5'd15;
  localparam logic [4:0] CLS_MEM_DST_EXE_SRC1  = 5'd16;
  localparam logic [4:0] CLS_MEM_DST_EXE_SRC2  = 5'd17;
  localparam logic [4:0] CLS_MEM_DST           = 5'd18;
  localparam logic [4:0] CLS_WB_DST            = 5'd19;
  localparam logic [4:0] CLS_LOAD_SRC1_MEM_SRC2 = 5'd20;
  localparam logic [4:0] CLS_LOAD_SRC1          = 5'd21;
  localparam logic [4:0] CLS_LOAD_SRC2_MEM_SRC1 = 5'd22;
  localparam logic [4:0] CLS_LOAD_SRC2          = 5'd23;
  localparam logic [4:0] CLS_LOAD_DST_MEM_SRC1  = 5'd24;
  localparam logic [4:0] CLS_LOAD_DST_MEM_SRC2  = 5'd25;
  localparam logic [4:0] CLS_LOAD_DST           = 5'd26;
  localparam logic [4:0] CLS_CONTROL            = 5'd27;

  // Configuration register indexes
  localparam logic CFG_FORWARD_ENABLE = 1'b0;
  localparam logic CFG_SPLIT_REGFILE  = 1'b1;

  // Stall groups
  localparam logic [1:0] GRP_OTHER = 2'd0;
  localparam logic [1:0] GRP_SHORT = 2'd1;
  localparam logic [1:0] GRP_LONG  = 2'd2;

  typedef struct packed {
    logic [3:0] id_opcode;
    logic [4:0] id_src1;
    logic [4:0] id_src2;
    logic       id_src2_is_imm;
    logic [4:0] id_dst;
    logic [3:0] exe_opcode;
    logic [4:0] exe_dst;
    logic [3:0] mem_opcode;
    logic [4:0] mem_dst;
    logic [3:0] wb_op;
    logic [4:0] wb_dst;
    logic       branch_resolved_taken;
  } phc_req_t;

  typedef struct packed {
    logic [4:0] hazard_class;
    logic       same_src1_src2;
    logic       same_src1_dst;
    logic       same_src2_dst;
    logic [1:0] stall_cycles;
  } phc_res_t;

  // Raw classification handed from the classifier to the stall stage
  typedef struct packed {
    logic [4:0] hazard_class;
    logic       same_src1_src2;
    logic       same_src1_dst;
    logic       same_src2_dst;
  } phc_cls_t;

  // Map opcodes above halt onto nop
  function automatic logic [3:0] norm_op(input logic [3:0] op);
    norm_op = (op > OP_HALT) ? OP_NOP : op;
  endfunction

  function automatic logic writes_dst(input logic [3:0] op);
    writes_dst = (op >= OP_ADD) && (op <= OP_LOAD);
  endfunction

  function automatic logic reads_dst(input logic [3:0] op);
    reads_dst = (op >= OP_STORE) && (op <= OP_BRNEQ);
  endfunction

  function automatic logic [1:0] stall_group(input logic [4:0] cls);
    case (cls)
      CLS_EXE_SRC1_MEM_SRC2, CLS_EXE_SRC1_WB_SRC2, CLS_EXE_SRC1,
      CLS_MEM_SRC1_EXE_SRC2, CLS_WB_SRC1_EXE_SRC2, CLS_EXE_SRC2,
      CLS_EXE_DST_MEM_SRC1, CLS_EXE_DST_MEM_SRC2, CLS_EXE_DST,
      CLS_MEM_DST_EXE_SRC1, CLS_MEM_DST_EXE_SRC2,
      CLS_LOAD_SRC1_MEM_SRC2, CLS_LOAD_SRC1, CLS_LOAD_SRC2_MEM_SRC1,
      CLS_LOAD_SRC2, CLS_LOAD_DST_MEM_SRC1, CLS_LOAD_DST_MEM_SRC2,
      CLS_LOAD_DST: stall_group = GRP_LONG;
      CLS_MEM_SRC1_WB_SRC2, CLS_MEM_SRC1, CLS_WB_SRC1_MEM_SRC2,
      CLS_MEM_SRC2, CLS_MEM_DST: stall_group = GRP_SHORT;
      default: stall_group = GRP_OTHER;
    endcase
  endfunction

endpackage

/* rtl/pipeline_hazard_classifier_unit.sv */
// Top level of the pipeline hazard classifier: request register, logic, result register.
//
// Usage:
//   Request channel: drive in_data and raise start; the request is taken at
//   any rising edge where start is high and busy is low. busy stays low, so a
//   new request can be issued every cycle.
//   Result channel: out_valid pulses for one cycle with out_data holding the
//   hazard class, the three equality flags and the stall count.
//   The result passes through the request register, then the result register.
//   Throughput: one request per cycle; the classify and stall logic between
//   the two registers is combinational.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index (0 forward
//   enable, 1 split register file). Write only while no request is in flight.
//   Reset (rst_n low, synchronous): both mode registers clear to 0 and any
//   request in flight is dropped.
//   The receiver cannot stall; each result must be taken in its strobe cycle.
module pipeline_hazard_classifier_unit
  import phc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  phc_req_t in_data,
  output logic     out_valid,
  output phc_res_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic     cfg_wdata
);

  logic     fwd_en_r, split_en_r;
  logic     req_valid_r, out_valid_r;
  phc_req_t req_r;
  phc_res_t res_r, res_nxt;
  phc_cls_t cls;

  assign busy = 1'b0;

  // Hold mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r   <= 1'b0;
      split_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORWARD_ENABLE: fwd_en_r   <= cfg_wdata;
        CFG_SPLIT_REGFILE:  split_en_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture request
  always_ff @(posedge clk) begin
    if (!rst_n) req_valid_r <= 1'b0;
    else        req_valid_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) req_r <= in_data;
  end

  phc_classify u_classify (
    .req (req_r),
    .cls (cls)
  );

  phc_stall u_stall (
    .cls                  (cls),
    .forward_enable       (fwd_en_r),
    .split_regfile_enable (split_en_r),
    .res                  (res_nxt)
  );

  // Advance result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= req_valid_r;
  end

  always_ff @(posedge clk) begin
    if (req_valid_r) res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule

/* rtl/phc_classify.sv */
// Priority classifier: hazard class and register-equality flags for one request.
module phc_classify
  import phc_pkg::*;
(
  input  phc_req_t req,
  output phc_cls_t cls
);

  logic [3:0] idop, exop, mmop, wbop;
  logic [4:0] s1, s2, d, exd, md, wd;
  logic       imm, ew, mw, ww;
  logic       load_hit, dst_hit, src_op;

  // Normalize opcodes, decode writers and compute the hit terms
  always_comb begin
    idop = norm_op(req.id_opcode);
    exop = norm_op(req.exe_opcode);
    mmop = norm_op(req.mem_opcode);
    wbop = norm_op(req.wb_op);
    s1   = req.id_src1;
    s2   = req.id_src2;
    d    = req.id_dst;
    imm  = req.id_src2_is_imm;
    exd  = req.exe_dst;
    md   = req.mem_dst;
    wd   = req.wb_dst;
    ew   = writes_dst(exop);
    mw   = writes_dst(mmop);
    ww   = writes_dst(wbop);
    load_hit = (exop == OP_LOAD) && ((exd == s1) || (!imm && (exd == s2)) || (exd == d));
    dst_hit  = reads_dst(idop) &&
               (((d == exd) && ew) || ((d == md) && mw) || ((d == wd) && ww));
    src_op   = (idop != OP_BR) && (idop != OP_NOP) && (idop != OP_HALT);
  end

  // Walk the priority order: control, load-use, destination read, source read
  always_comb begin
    cls = '0;
    if (req.branch_resolved_taken) begin
      cls.hazard_class = CLS_CONTROL;
    end else if (load_hit) begin
      if (exd == s1) begin
        cls.hazard_class = (!imm && (s2 == md) && mw) ? CLS_LOAD_SRC1_MEM_SRC2
                                                      : CLS_LOAD_SRC1;
      end else if (!imm && (exd == s2)) begin
        cls.hazard_class = ((s1 == md) && mw) ? CLS_LOAD_SRC2_MEM_SRC1 : CLS_LOAD_SRC2;
      end else if ((s1 == md) && mw) begin
        cls.hazard_class = CLS_LOAD_DST_MEM_SRC1;
      end else if (!imm && (s2 == md) && mw) begin
        cls.hazard_class = CLS_LOAD_DST_MEM_SRC2;
      end else begin
        cls.hazard_class = CLS_LOAD_DST;
      end
    end else if (dst_hit) begin
      if ((d == exd) && ew) begin
        cls.hazard_class = CLS_EXE_DST;
        if (idop != OP_BR) begin
          cls.same_src1_dst = (s1 == d);
          if (!imm) cls.same_src2_dst = (s2 == d);
          if (!imm && (s2 == md) && mw && (s1 != s2)) begin
            cls.hazard_class = CLS_EXE_DST_MEM_SRC2;
          end else begin
            if (!imm && (s2 == md) && mw) cls.same_src1_src2 = 1'b1;
            if ((s1 == md) && mw) cls.hazard_class = CLS_EXE_DST_MEM_SRC1;
          end
        end
      end else if ((d == md) && mw) begin
        cls.hazard_class = CLS_MEM_DST;
        if (idop != OP_BR) begin
          cls.same_src1_dst = (s1 == d);
          if (!imm) cls.same_src2_dst = (s2 == d);
          if (!imm && (s2 == exd) && ew && (s1 != s2)) begin
            cls.hazard_class = CLS_MEM_DST_EXE_SRC2;
          end else begin
            if (!imm && (s2 == exd) && ew) cls.same_src1_src2 = 1'b1;
            if ((s1 == exd) && ew) cls.hazard_class = CLS_MEM_DST_EXE_SRC1;
          end
        end
      end else begin
        cls.hazard_class = CLS_WB_DST;
      end
    end else if (src_op) begin
      if ((s1 == exd) && ew) begin
        cls.hazard_class = CLS_EXE_SRC1;
        if (!imm && (s2 == s1)) cls.same_src1_src2 = 1'b1;
        else if (!imm && (s2 == md) && mw) cls.hazard_class = CLS_EXE_SRC1_MEM_SRC2;
        else if (!imm && (s2 == wd) && ww) cls.hazard_class = CLS_EXE_SRC1_WB_SRC2;
      end else if ((s1 == md) && mw) begin
        cls.hazard_class = CLS_MEM_SRC1;
        if (!imm && (s2 == s1)) cls.same_src1_src2 = 1'b1;
        else if (!imm && (s2 == exd) && ew) cls.hazard_class = CLS_MEM_SRC1_EXE_SRC2;
        else if (!imm && (s2 == wd) && ww) cls.hazard_class = CLS_MEM_SRC1_WB_SRC2;
      end else if ((s1 == wd) && ww) begin
        if (!imm && (s2 == exd) && ew) cls.hazard_class = CLS_WB_SRC1_EXE_SRC2;
        else if (!imm && (s2 == md) && mw) cls.hazard_class = CLS_WB_SRC1_MEM_SRC2;
        else cls.hazard_class = CLS_WB_SRC1;
      end else if (!imm) begin
        if ((s2 == exd) && ew) cls.hazard_class = CLS_EXE_SRC2;
        else if ((s2 == md) && mw) cls.hazard_class = CLS_MEM_SRC2;
        else if ((s2 == wd) && ww) cls.hazard_class = CLS_WB_SRC2;
      end
    end
  end

endmodule

/* rtl/phc_stall.sv */
// Stall cycle count and split-mode demotion under the configured forwarding mode.
module phc_stall
  import phc_pkg::*;
(
  input  phc_cls_t cls,
  input  logic     forward_enable,
  input  logic     split_regfile_enable,
  output phc_res_t res
);

  logic [1:0] grp;
  logic       data_cls;
  logic       load_cls;

  always_comb begin
    grp      = stall_group(cls.hazard_class);
    data_cls = (cls.hazard_class != CLS_NONE) && (cls.hazard_class != CLS_CONTROL);
    load_cls = (cls.hazard_class >= CLS_LOAD_SRC1_MEM_SRC2) &&
               (cls.hazard_class <= CLS_LOAD_DST);
  end

  // Pick the stall count; drop unlisted classes in split mode with forwarding off
  always_comb begin
    res.hazard_class   = cls.hazard_class;
    res.same_src1_src2 = cls.same_src1_src2;
    res.same_src1_dst  = cls.same_src1_dst;
    res.same_src2_dst  = cls.same_src2_dst;
    res.stall_cycles   = 2'd0;
    if (data_cls) begin
      if (forward_enable) begin
        res.stall_cycles = {1'b0, load_cls};
      end else if (split_regfile_enable) begin
        if (grp == GRP_OTHER) res.hazard_class = CLS_NONE;
        else res.stall_cycles = grp;
      end else begin
        res.stall_cycles = grp + 2'd1;
      end
    end
  end

endmodule

/* rtl/phc_checker.sv */
// Port-level checker for the hazard classifier, bound to the top level.
module phc_checker
  import phc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input phc_res_t out_data,
  input logic     out_valid
);

  // Every taken request yields a result through the request and result registers
  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("request produced no result");

  // No result without a taken request ahead of the request and result registers
  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without request");

  // Control hazard carries no flags and no stall
  a_control_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.hazard_class == CLS_CONTROL)) |->
      (!out_data.same_src1_src2 && !out_data.same_src1_dst &&
       !out_data.same_src2_dst && (out_data.stall_cycles == 2'd0)))
    else $error("control hazard with flags or stall");

  // No hazard never stalls
  a_none_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.hazard_class == CLS_NONE)) |->
      (out_data.stall_cycles == 2'd0))
    else $error("stall without hazard");

endmodule

bind pipeline_hazard_classifier_unit phc_checker u_phc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_data  (out_data),
  .out_valid (out_valid)
);
